### hw/rtl/bkm_pkg.sv
`default_nettype none

package bkm_pkg;

  localparam int PHASE_BITS_DEF          = 32;
  localparam int TABLE_BITS_DEF          = 10;
  localparam int SAMPLE_BITS_DEF         = 16;
  localparam int MAX_SAMPLES_PER_BIT_DEF = 64;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 5;
  localparam int REG_IDX_W  = 3;
  localparam int SPB_W      = 7;
  localparam int STEP_W     = 32;
  localparam int AMP_W      = 15;
  localparam int AMP_FRAC   = 15;

  localparam logic [REG_IDX_W-1:0] REG_MODE         = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SPB          = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_STEP_CARRIER = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_STEP_SPACE   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_STEP_MARK    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_AMP_ZERO     = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_AMP_ONE      = 3'd6;

  localparam logic [SPB_W-1:0]  SPB_RST          = 7'd10;
  localparam logic [STEP_W-1:0] STEP_CARRIER_RST = 32'd42949673;
  localparam logic [STEP_W-1:0] STEP_SPACE_RST   = 32'd34359738;
  localparam logic [STEP_W-1:0] STEP_MARK_RST    = 32'd51539608;
  localparam logic [AMP_W-1:0]  AMP_ZERO_RST     = 15'd6554;
  localparam logic [AMP_W-1:0]  AMP_ONE_RST      = 15'd32767;

  localparam logic [63:0] PI_Q30 = 64'd3373259426;
  localparam logic [9:0] TAYLOR_DIV [16] = '{
    10'd1, 10'd6, 10'd20, 10'd42, 10'd72, 10'd110, 10'd156, 10'd210,
    10'd272, 10'd342, 10'd420, 10'd506, 10'd600, 10'd702, 10'd812, 10'd930
  };

  typedef enum logic [1:0] {
    MODE_ASK  = 2'd0,
    MODE_FSK  = 2'd1,
    MODE_PSK  = 2'd2,
    MODE_NONE = 2'd3
  } bkm_mode_e;

  typedef struct packed {
    bkm_mode_e         mode;
    logic [SPB_W-1:0]  spb;
    logic [STEP_W-1:0] step_carrier;
    logic [STEP_W-1:0] step_space;
    logic [STEP_W-1:0] step_mark;
    logic [AMP_W-1:0]  amp_zero;
    logic [AMP_W-1:0]  amp_one;
  } bkm_cfg_t;

  typedef struct packed {
    logic             valid;
    logic             neg;
    logic             last;
    bkm_mode_e        mode;
    logic [AMP_W-1:0] amp;
  } bkm_stage_t;

  // Quarter-wave sine value in Q2.30, Taylor series, scaled to full amplitude
  function automatic logic [31:0] bkm_quarter_value(input int unsigned k,
                                                    input int unsigned tb,
                                                    input int unsigned sb);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] full_amp;
    longint      sum;
    longint      v;
    x        = ((64'(k) * PI_Q30) + (64'd1 << (tb - 2))) >> (tb - 1);
    x2       = (x * x) >> 30;
    term     = x;
    sum      = longint'(x);
    full_amp = (64'd1 << (sb - 1)) - 64'd1;
    for (int n = 1; n < 16; n++) begin
      if (term != 64'd0) begin
        term = ((term * x2) >> 30) / 64'(TAYLOR_DIV[n]);
        if (n[0]) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    v = (sum * longint'(full_amp) + (longint'(1) <<< 29)) >>> 30;
    if (v > longint'(full_amp)) begin
      v = longint'(full_amp);
    end
    return 32'(v);
  endfunction

endpackage

`default_nettype wire

### hw/rtl/bkm_cfg.sv
`default_nettype none

module bkm_cfg (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [bkm_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [bkm_pkg::CFG_DATA_W-1:0] pwdata,
  output      logic [bkm_pkg::CFG_DATA_W-1:0] prdata,
  output      logic                           pready,
  output      bkm_pkg::bkm_cfg_t              cfg_o
);
  import bkm_pkg::*;

  bkm_cfg_t             cfg_q;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode         <= MODE_ASK;
      cfg_q.spb          <= SPB_RST;
      cfg_q.step_carrier <= STEP_CARRIER_RST;
      cfg_q.step_space   <= STEP_SPACE_RST;
      cfg_q.step_mark    <= STEP_MARK_RST;
      cfg_q.amp_zero     <= AMP_ZERO_RST;
      cfg_q.amp_one      <= AMP_ONE_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_MODE:         cfg_q.mode         <= bkm_mode_e'(pwdata[1:0]);
        REG_SPB:          cfg_q.spb          <= pwdata[SPB_W-1:0];
        REG_STEP_CARRIER: cfg_q.step_carrier <= pwdata[STEP_W-1:0];
        REG_STEP_SPACE:   cfg_q.step_space   <= pwdata[STEP_W-1:0];
        REG_STEP_MARK:    cfg_q.step_mark    <= pwdata[STEP_W-1:0];
        REG_AMP_ZERO:     cfg_q.amp_zero     <= pwdata[AMP_W-1:0];
        REG_AMP_ONE:      cfg_q.amp_one      <= pwdata[AMP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MODE:         prdata = CFG_DATA_W'(cfg_q.mode);
      REG_SPB:          prdata = CFG_DATA_W'(cfg_q.spb);
      REG_STEP_CARRIER: prdata = CFG_DATA_W'(cfg_q.step_carrier);
      REG_STEP_SPACE:   prdata = CFG_DATA_W'(cfg_q.step_space);
      REG_STEP_MARK:    prdata = CFG_DATA_W'(cfg_q.step_mark);
      REG_AMP_ZERO:     prdata = CFG_DATA_W'(cfg_q.amp_zero);
      REG_AMP_ONE:      prdata = CFG_DATA_W'(cfg_q.amp_one);
      default:          prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/bkm_gen.sv
`default_nettype none

module bkm_gen #(
  parameter int PHASE_BITS          = bkm_pkg::PHASE_BITS_DEF,
  parameter int TABLE_BITS          = bkm_pkg::TABLE_BITS_DEF,
  parameter int SAMPLE_BITS         = bkm_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_SAMPLES_PER_BIT = bkm_pkg::MAX_SAMPLES_PER_BIT_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire bkm_pkg::bkm_cfg_t      cfg_i,
  input  wire logic                   in_valid_i,
  output      logic                   in_stall_o,
  input  wire logic                   bit_value_i,
  input  wire logic                   first_i,
  input  wire logic                   adv_i,
  output      bkm_pkg::bkm_stage_t    stage_o,
  output      logic [SAMPLE_BITS-2:0] mag_o
);
  import bkm_pkg::*;

  localparam int MAG_W   = SAMPLE_BITS - 1;
  localparam int CNT_W   = $clog2(MAX_SAMPLES_PER_BIT);
  localparam int LIM_W   = CNT_W + 1;
  localparam int QUARTER = 1 << (TABLE_BITS - 2);
  localparam logic [MAG_W-1:0] ROM_TOP =
    MAG_W'(bkm_quarter_value(QUARTER, TABLE_BITS, SAMPLE_BITS));
  localparam logic [PHASE_BITS-1:0] HALF_TURN = {1'b1, {(PHASE_BITS-1){1'b0}}};

  logic [MAG_W-1:0] rom [QUARTER];

  for (genvar k = 0; k < QUARTER; k++) begin : g_rom
    assign rom[k] = MAG_W'(bkm_quarter_value(k, TABLE_BITS, SAMPLE_BITS));
  end

  logic                  item_q, item_d;
  logic                  bit_q, first_q;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [PHASE_BITS-1:0] ph_c_q, ph_s_q, ph_m_q;
  logic [PHASE_BITS-1:0] base_c, base_s, base_m, sel_ph;
  logic [PHASE_BITS-1:0] step_c, step_s, step_m;
  logic [LIM_W-1:0]      lim;
  logic                  last, issue, accept, restart;
  logic [TABLE_BITS-1:0] idx;
  logic [1:0]            quad;
  logic [TABLE_BITS-3:0] r;
  logic [TABLE_BITS-2:0] qidx;
  logic [MAG_W-1:0]      mag_d;
  bkm_stage_t            stage_q;
  logic [MAG_W-1:0]      mag_q;

  assign step_c = PHASE_BITS'(cfg_i.step_carrier);
  assign step_s = PHASE_BITS'(cfg_i.step_space);
  assign step_m = PHASE_BITS'(cfg_i.step_mark);

  always_comb begin
    if (cfg_i.spb == '0) begin
      lim = LIM_W'(1);
    end else if (cfg_i.spb > SPB_W'(MAX_SAMPLES_PER_BIT)) begin
      lim = LIM_W'(MAX_SAMPLES_PER_BIT);
    end else begin
      lim = LIM_W'(cfg_i.spb);
    end
  end

  assign last       = ({1'b0, cnt_q} + LIM_W'(1)) == lim;
  assign issue      = item_q && adv_i;
  assign in_stall_o = item_q && !(issue && last);
  assign accept     = in_valid_i && !in_stall_o;
  assign restart    = (cnt_q == '0) && first_q;

  assign base_c = restart ? '0 : ph_c_q;
  assign base_s = restart ? '0 : ph_s_q;
  assign base_m = restart ? '0 : ph_m_q;

  always_comb begin
    unique case (cfg_i.mode)
      MODE_FSK: sel_ph = bit_q ? base_m : base_s;
      MODE_PSK: sel_ph = bit_q ? base_c + HALF_TURN : base_c;
      default:  sel_ph = base_c;
    endcase
  end

  assign idx   = sel_ph[PHASE_BITS-1 -: TABLE_BITS];
  assign quad  = idx[TABLE_BITS-1:TABLE_BITS-2];
  assign r     = idx[TABLE_BITS-3:0];
  assign qidx  = quad[0] ? (TABLE_BITS-1)'(QUARTER) - {1'b0, r} : {1'b0, r};
  assign mag_d = qidx[TABLE_BITS-2] ? ROM_TOP : rom[qidx[TABLE_BITS-3:0]];

  always_comb begin
    item_d = item_q;
    cnt_d  = cnt_q;
    if (issue) begin
      cnt_d = last ? '0 : cnt_q + CNT_W'(1);
      if (last) begin
        item_d = 1'b0;
      end
    end
    if (accept) begin
      item_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_q <= 1'b0;
      cnt_q  <= '0;
      ph_c_q <= '0;
      ph_s_q <= '0;
      ph_m_q <= '0;
    end else begin
      item_q <= item_d;
      cnt_q  <= cnt_d;
      if (issue) begin
        ph_c_q <= base_c + step_c;
        ph_s_q <= base_s + step_s;
        ph_m_q <= base_m + step_m;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      bit_q   <= bit_value_i;
      first_q <= first_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
      mag_q   <= '0;
    end else begin
      if (adv_i) begin
        stage_q.valid <= issue;
      end
      if (issue) begin
        stage_q.neg  <= quad[1];
        stage_q.last <= last;
        stage_q.mode <= cfg_i.mode;
        stage_q.amp  <= bit_q ? cfg_i.amp_one : cfg_i.amp_zero;
        mag_q        <= mag_d;
      end
    end
  end

  assign stage_o = stage_q;
  assign mag_o   = mag_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) !item_q |-> cnt_q == '0)
    else $error("sample counter not at zero while idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni) !item_q |-> !in_stall_o)
    else $error("request stalled while idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   item_q |-> {1'b0, cnt_q} < lim)
    else $error("sample counter beyond count");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   issue && last && !accept |=> !item_q)
    else $error("request held after its last sample");

endmodule

`default_nettype wire

### hw/rtl/bkm_out.sv
`default_nettype none

module bkm_out #(
  parameter int SAMPLE_BITS = bkm_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire bkm_pkg::bkm_stage_t           stage_i,
  input  wire logic [SAMPLE_BITS-2:0]        mag_i,
  output      logic                          adv_o,
  output      logic                          out_valid_o,
  input  wire logic                          out_stall_i,
  output      logic signed [SAMPLE_BITS-1:0] sample_o,
  output      logic                          last_o
);
  import bkm_pkg::*;

  localparam int PROD_W = SAMPLE_BITS + AMP_W + 1;

  logic signed [SAMPLE_BITS-1:0] sine;
  logic signed [AMP_W:0]         amp_s;
  logic signed [PROD_W-1:0]      prod;
  logic signed [SAMPLE_BITS-1:0] sample_d, sample_q;
  logic                          valid_q, last_q;

  assign sine  = stage_i.neg ? -$signed({1'b0, mag_i}) : $signed({1'b0, mag_i});
  assign amp_s = $signed({1'b0, stage_i.amp});
  assign prod  = PROD_W'(sine) * PROD_W'(amp_s);

  always_comb begin
    unique case (stage_i.mode)
      MODE_ASK:  sample_d = prod[SAMPLE_BITS+AMP_FRAC-1:AMP_FRAC];
      MODE_FSK:  sample_d = sine;
      MODE_PSK:  sample_d = sine;
      MODE_NONE: sample_d = '0;
      default:   sample_d = '0;
    endcase
  end

  assign adv_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_o) begin
      valid_q <= stage_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && stage_i.valid) begin
      sample_q <= sample_d;
      last_q   <= stage_i.last;
    end
  end

  assign out_valid_o = valid_q;
  assign sample_o    = sample_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

### hw/rtl/binary_keying_modulator_unit.sv
// Binary ASK / FSK / PSK modulator.
// Input channel (in_valid_i / in_stall_o) carries one message bit and a
// first flag per request; first clears the carrier, space and mark phase
// accumulators so that the first sample of a frame starts at phase zero.
// Output channel (out_valid_o / out_stall_i) carries one signed sample per
// transfer; last_o marks the final sample of a bit.
// Each request yields the programmed sample count (zero counts as one, values
// above MAX_SAMPLES_PER_BIT saturate), one per cycle while the output does not
// stall, so a request occupies the sample generator until its last sample is
// issued; the next request is taken in the cycle its predecessor's last sample
// leaves the generator. A request's first sample passes the input register,
// the generator register, then the multiply and the output register.
// Reset clears all phase accumulators, the sample counter and the valid bits,
// and loads the register defaults. Write the APB registers only while idle.
// A stall at the output holds the output register and freezes the generator;
// one further request may still be taken into the input register meanwhile.
`default_nettype none

module binary_keying_modulator_unit #(
  parameter int PHASE_BITS          = bkm_pkg::PHASE_BITS_DEF,
  parameter int TABLE_BITS          = bkm_pkg::TABLE_BITS_DEF,
  parameter int SAMPLE_BITS         = bkm_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_SAMPLES_PER_BIT = bkm_pkg::MAX_SAMPLES_PER_BIT_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [bkm_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [bkm_pkg::CFG_DATA_W-1:0] pwdata,
  output      logic [bkm_pkg::CFG_DATA_W-1:0] prdata,
  output      logic                           pready,
  input  wire logic                           in_valid_i,
  output      logic                           in_stall_o,
  input  wire logic                           bit_value_i,
  input  wire logic                           first_i,
  output      logic                           out_valid_o,
  input  wire logic                           out_stall_i,
  output      logic signed [SAMPLE_BITS-1:0]  sample_o,
  output      logic                           last_o
);
  import bkm_pkg::*;

  bkm_cfg_t               cfg;
  bkm_stage_t             stage;
  logic [SAMPLE_BITS-2:0] mag;
  logic                   adv;

  bkm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bkm_gen #(
    .PHASE_BITS          (PHASE_BITS),
    .TABLE_BITS          (TABLE_BITS),
    .SAMPLE_BITS         (SAMPLE_BITS),
    .MAX_SAMPLES_PER_BIT (MAX_SAMPLES_PER_BIT)
  ) u_gen (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .bit_value_i (bit_value_i),
    .first_i     (first_i),
    .adv_i       (adv),
    .stage_o     (stage),
    .mag_o       (mag)
  );

  bkm_out #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stage_i     (stage),
    .mag_i       (mag),
    .adv_o       (adv),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sample_o    (sample_o),
    .last_o      (last_o)
  );

endmodule

`default_nettype wire

### tb/tb_binary_keying_modulator_unit.sv
`default_nettype none

module tb_binary_keying_modulator_unit;
  import bkm_pkg::*;

  localparam int PB    = PHASE_BITS_DEF;
  localparam int TBL   = TABLE_BITS_DEF;
  localparam int SB    = SAMPLE_BITS_DEF;
  localparam int MAXS  = MAX_SAMPLES_PER_BIT_DEF;
  localparam int QTR   = 1 << (TBL - 2);
  localparam longint FULL_SCALE = (longint'(1) << (SB - 1)) - 1;
  localparam bit [PB-1:0] HALF_TURN = {1'b1, {(PB - 1){1'b0}}};
  localparam int IDLE_PCT = 28;
  localparam int HOLDOFF_CYCLES = 250;

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   psel        = 1'b0;
  logic                   penable     = 1'b0;
  logic                   pwrite      = 1'b0;
  logic [CFG_ADDR_W-1:0]  paddr       = '0;
  logic [CFG_DATA_W-1:0]  pwdata      = '0;
  logic [CFG_DATA_W-1:0]  prdata;
  logic                   pready;
  logic                   in_valid_i  = 1'b0;
  logic                   in_stall_o;
  logic                   bit_value_i = 1'b0;
  logic                   first_i     = 1'b0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic signed [SB-1:0]   sample_o;
  logic                   last_o;

  bit quiet       = 1'b0;
  bit holdoff_req = 1'b0;

  binary_keying_modulator_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .bit_value_i (bit_value_i),
    .first_i     (first_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sample_o    (sample_o),
    .last_o      (last_o)
  );

  typedef struct {
    logic signed [SB-1:0] sample;
    logic                 last;
  } keyed_sample_t;

  class keyer_prediction;
    int              quarter_wave [0:QTR];
    bkm_mode_e       mode;
    bit [SPB_W-1:0]  spb;
    bit [STEP_W-1:0] step_carrier;
    bit [STEP_W-1:0] step_space;
    bit [STEP_W-1:0] step_mark;
    bit [AMP_W-1:0]  amp_zero;
    bit [AMP_W-1:0]  amp_one;
    bit [PB-1:0]     ph_carrier;
    bit [PB-1:0]     ph_space;
    bit [PB-1:0]     ph_mark;
    keyed_sample_t   due_samples [$];
    int              mismatches;

    function new();
      for (int k = 0; k <= QTR; k++) begin
        quarter_wave[k] = quarter_sine(k);
      end
      mode         = MODE_ASK;
      spb          = SPB_RST;
      step_carrier = STEP_CARRIER_RST;
      step_space   = STEP_SPACE_RST;
      step_mark    = STEP_MARK_RST;
      amp_zero     = AMP_ZERO_RST;
      amp_one      = AMP_ONE_RST;
      ph_carrier   = '0;
      ph_space     = '0;
      ph_mark      = '0;
      mismatches   = 0;
    endfunction

    function int quarter_sine(int unsigned k);
      bit [63:0] x;
      bit [63:0] x2;
      bit [63:0] term;
      longint    acc;
      longint    v;
      x    = (64'(k) * PI_Q30 + (64'd1 << (TBL - 2))) >> (TBL - 1);
      x2   = (x * x) >> 30;
      term = x;
      acc  = longint'(x);
      for (int unsigned n = 1; n < 16 && term != 0; n++) begin
        term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          acc = acc - longint'(term);
        end else begin
          acc = acc + longint'(term);
        end
      end
      if (acc < 0) begin
        acc = 0;
      end
      v = (acc * FULL_SCALE + (longint'(1) << 29)) >>> 30;
      if (v > FULL_SCALE) begin
        v = FULL_SCALE;
      end
      return int'(v);
    endfunction

    function int sine_at(bit [PB-1:0] ph);
      bit [TBL-1:0] idx;
      bit [1:0]     quad;
      int           r;
      int           v;
      idx  = ph[PB-1 -: TBL];
      quad = idx[TBL-1 -: 2];
      r    = int'(idx[TBL-3:0]);
      v    = quad[0] ? quarter_wave[QTR - r] : quarter_wave[r];
      return quad[1] ? -v : v;
    endfunction

    function void set_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_MODE:         mode = bkm_mode_e'(val[1:0]);
        REG_SPB:          spb = val[SPB_W-1:0];
        REG_STEP_CARRIER: step_carrier = val[STEP_W-1:0];
        REG_STEP_SPACE:   step_space = val[STEP_W-1:0];
        REG_STEP_MARK:    step_mark = val[STEP_W-1:0];
        REG_AMP_ZERO:     amp_zero = val[AMP_W-1:0];
        REG_AMP_ONE:      amp_one = val[AMP_W-1:0];
        default: ;
      endcase
    endfunction

    function void accept_bit(logic b, logic f);
      int            count;
      longint        prod;
      int            s;
      keyed_sample_t e;
      count = int'(spb);
      if (count == 0) begin
        count = 1;
      end
      if (count > MAXS) begin
        count = MAXS;
      end
      if (f) begin
        ph_carrier = '0;
        ph_space   = '0;
        ph_mark    = '0;
      end
      for (int j = 0; j < count; j++) begin
        case (mode)
          MODE_ASK: begin
            prod = longint'(sine_at(ph_carrier)) * longint'(b ? amp_one : amp_zero);
            s    = int'(prod >>> AMP_FRAC);
          end
          MODE_FSK: s = sine_at(b ? ph_mark : ph_space);
          MODE_PSK: s = sine_at(b ? ph_carrier + HALF_TURN : ph_carrier);
          default:  s = 0;
        endcase
        e.sample = s[SB-1:0];
        e.last   = (j == count - 1);
        due_samples.push_back(e);
        ph_carrier = ph_carrier + step_carrier;
        ph_space   = ph_space + step_space;
        ph_mark    = ph_mark + step_mark;
      end
    endfunction

    task report_mismatch(string what, longint got, longint want);
      $display("tb: mismatch on %s: got %0d, want %0d at %0t", what, got, want, $realtime);
      mismatches++;
    endtask

    task check_sample(logic signed [SB-1:0] got, logic got_last);
      keyed_sample_t e;
      if (due_samples.size() == 0) begin
        report_mismatch("unexpected sample", got, 0);
      end else begin
        e = due_samples.pop_front();
        if (got !== e.sample) begin
          report_mismatch("sample", got, e.sample);
        end
        if (got_last !== e.last) begin
          report_mismatch("last", got_last, e.last);
        end
      end
    endtask
  endclass

  keyer_prediction keyer;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    #4000000;
    $display("tb: failure");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      keyer.check_sample(sample_o, last_o);
    end
  end

  // output side: random stalls, one long hold-off on request
  initial begin
    forever begin
      @(negedge clk_i);
      if (holdoff_req) begin
        holdoff_req = 1'b0;
        out_stall_i = 1'b1;
        repeat (HOLDOFF_CYCLES) @(negedge clk_i);
      end else begin
        out_stall_i = !quiet && ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  task automatic send_bit(input logic b, input logic f);
    @(negedge clk_i);
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  = 1'b1;
    bit_value_i = b;
    first_i     = f;
    do @(posedge clk_i); while (in_stall_o);
    keyer.accept_bit(b, f);
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (keyer.due_samples.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = val;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    keyer.set_reg(idx, val);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  initial begin
    bkm_mode_e keyings [3];
    int        spb_pick;
    keyings = '{MODE_ASK, MODE_FSK, MODE_PSK};
    keyer = new();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_bit(1'b1, 1'b1);
    send_bit(1'b0, 1'b0);
    send_bit(1'b1, 1'b0);
    send_bit(1'b0, 1'b1);
    settle();
    write_reg(REG_MODE, MODE_FSK);
    send_bit(1'b0, 1'b1);
    send_bit(1'b1, 1'b0);
    settle();
    write_reg(REG_MODE, MODE_PSK);
    send_bit(1'b0, 1'b1);
    send_bit(1'b1, 1'b0);
    send_bit(1'b1, 1'b1);
    settle();
    write_reg(REG_MODE, MODE_NONE);
    send_bit(1'b1, 1'b1);
    send_bit(1'b0, 1'b0);
    settle();
    write_reg(REG_MODE, MODE_ASK);
    write_reg(REG_SPB, 32'd0);
    send_bit(1'b1, 1'b0);
    send_bit(1'b0, 1'b0);
    settle();
    write_reg(REG_SPB, 32'd127);
    send_bit(1'b1, 1'b0);
    settle();
    write_reg(REG_SPB, 32'd64);
    write_reg(REG_STEP_CARRIER, 32'hFFFF_FFFF);
    write_reg(REG_STEP_SPACE, 32'hFFFF_FFFF);
    write_reg(REG_STEP_MARK, 32'hFFFF_FFFF);
    write_reg(REG_AMP_ZERO, 32'd32767);
    write_reg(REG_AMP_ONE, 32'd0);
    send_bit(1'b0, 1'b0);
    send_bit(1'b1, 1'b0);
    settle();
    write_reg(REG_MODE, MODE_FSK);
    write_reg(REG_SPB, 32'd1);
    write_reg(REG_STEP_CARRIER, 32'd0);
    write_reg(REG_STEP_SPACE, 32'd0);
    write_reg(REG_STEP_MARK, 32'd0);
    send_bit(1'b1, 1'b1);
    send_bit(1'b0, 1'b0);
    settle();
    write_reg(REG_MODE, MODE_PSK);
    send_bit(1'b1, 1'b0);
    send_bit(1'b0, 1'b1);

    for (int p = 0; p < 12; p++) begin
      settle();
      if (p == 7) begin
        write_reg(REG_MODE, MODE_NONE);
      end else begin
        write_reg(REG_MODE, keyings[p % 3]);
      end
      case (p)
        3:       spb_pick = 64;
        5:       spb_pick = $urandom_range(0, 9);
        9:       spb_pick = $urandom_range(65, 127);
        default: spb_pick = $urandom_range(10, 14);
      endcase
      write_reg(REG_SPB, 32'(spb_pick));
      write_reg(REG_STEP_CARRIER, $urandom);
      write_reg(REG_STEP_SPACE, $urandom);
      write_reg(REG_STEP_MARK, $urandom);
      if (p == 2) begin
        write_reg(REG_AMP_ZERO, 32'd0);
        write_reg(REG_AMP_ONE, 32'd32767);
      end else begin
        write_reg(REG_AMP_ZERO, $urandom_range(0, 32767));
        write_reg(REG_AMP_ONE, $urandom_range(0, 32767));
      end
      quiet = (p == 4);
      for (int i = 0; i < 38; i++) begin
        send_bit($urandom_range(0, 1), $urandom_range(0, 9) == 0);
        if (p == 6 && i == 4) begin
          holdoff_req = 1'b1;
        end
      end
    end

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (keyer.due_samples.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (keyer.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
